// File: rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg: shared types and constants for the MD5 hash engine
// Request payload structs, queue entry, sequencer states and step ROMs.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;
  } md5_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_end;
  } md5_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_EMIT
  } md5_state_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [5:0]  LEN_SLOT = 6'd56;

  function automatic logic [31:0] step_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] step_shift(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index used at step i
  function automatic logic [3:0] step_word(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

// File: rtl/md5_hash_engine.sv
// ----------------------------------------------------------------------------
// md5_hash_engine: MD5 message digest, one message byte per request
// Front intake queue feeding a byte-packing and round engine.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall / in_data (data_byte, byte_present,
//                 message_end). Requests with neither byte nor end are
//                 absorbed with no effect.
//   out channel : out_valid / out_stall / out_data; four words A, B, C, D
//                 per message, last_word set on D.
// Timing:
//   A byte fills one slot in the back end; every 64th byte starts a
//   compression (one MD5 step per cycle), and no bytes are taken meanwhile.
//   The end request pads one slot per cycle up to the length field, plus
//   one or two compressions, then the four result words.
//   A 4-entry queue lets the sender keep pushing while the back end runs.
// Reset: synchronous, clears queue and restores MD5 initial values.
// A stalled result holds; the engine waits, the queue keeps filling.
// ----------------------------------------------------------------------------
module md5_hash_engine
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  md5_in_t  in_data,
  output logic     in_stall,
  output logic     out_valid,
  output md5_out_t out_data,
  input  logic     out_stall
);

  logic     cmd_valid;
  logic     cmd_pop;
  md5_cmd_t cmd_data;

  md5_front u_front (
    .clk, .rst, .in_valid, .in_data, .in_stall,
    .cmd_valid, .cmd_data, .cmd_pop
  );

  md5_back u_back (
    .clk, .rst, .cmd_valid, .cmd_data, .cmd_pop,
    .out_valid, .out_data, .out_stall
  );

endmodule

// File: rtl/md5_front.sv
// ----------------------------------------------------------------------------
// md5_front: request intake and classification
// Drops empty requests and pushes the rest into a small queue.
// ----------------------------------------------------------------------------
module md5_front
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  md5_in_t  in_data,
  output logic     in_stall,
  output logic     cmd_valid,
  output md5_cmd_t cmd_data,
  input  logic     cmd_pop
);

  localparam int Depth = 4;

  md5_cmd_t   queue [Depth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       useful;

  assign in_stall  = (count == 3'(Depth));
  assign useful    = in_data.byte_present | in_data.message_end;
  assign push      = in_valid & ~in_stall & useful;
  assign cmd_valid = (count != 3'd0);
  assign cmd_data  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{data_byte: in_data.data_byte,
                         has_byte: in_data.byte_present,
                         is_end: in_data.message_end};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (cmd_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(cmd_pop);
    end
  end

endmodule

// File: rtl/md5_back.sv
// ----------------------------------------------------------------------------
// md5_back: byte packing, padding and the MD5 round engine
// One byte slot per cycle while not compressing or emitting, one compression step per cycle.
// ----------------------------------------------------------------------------
module md5_back
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  input  md5_cmd_t cmd_data,
  output logic     cmd_pop,
  output logic     out_valid,
  output md5_out_t out_data,
  input  logic     out_stall
);

  md5_state_t  state, state_next;
  logic [31:0] buf_mem [16];
  logic [31:0] cha, chb, chc, chd;
  logic [31:0] wa, wb, wc, wd;
  logic [63:0] bit_length;
  logic [63:0] len_latch;
  logic [5:0]  byte_position;
  logic [5:0]  step_index;
  logic [1:0]  emit_idx;
  md5_state_t  resume;       // where to go after a compression
  logic        ending;

  // byte slot write
  logic        put;
  logic [7:0]  put_byte;
  logic        cmd_take;
  logic [31:0] m_word;
  logic [31:0] f_val, sum, rot;
  logic [4:0]  sh;
  logic        out_take;

  assign out_take = out_valid & ~out_stall;

  always_comb begin
    cmd_take = 1'b0;
    put      = 1'b0;
    put_byte = PAD_MARK;
    unique case (state)
      ST_IDLE: begin
        cmd_take = cmd_valid;
        put      = cmd_valid & cmd_data.has_byte;
        put_byte = cmd_data.data_byte;
      end
      ST_PAD: begin
        put      = 1'b1;
        put_byte = ending ? PAD_MARK : 8'h00;
      end
      ST_LEN: begin
        put      = 1'b1;
        put_byte = len_latch[8 * (byte_position[2:0]) +: 8];
      end
      ST_COMP, ST_EMIT: ;
      default: ;
    endcase
  end
  assign cmd_pop = cmd_take;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          if (put && byte_position == 6'd63) state_next = ST_COMP;
          else if (cmd_data.is_end) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (byte_position == 6'd63) state_next = ST_COMP;
        else if (byte_position + 6'd1 == LEN_SLOT) state_next = ST_LEN;
      end
      ST_LEN: if (byte_position == 6'd63) state_next = ST_COMP;
      ST_COMP: if (step_index == 6'd63) state_next = resume;
      ST_EMIT: if (out_take && emit_idx == 2'd3) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // round function
  assign m_word = buf_mem[step_word(step_index)];
  always_comb begin
    case (step_index[5:4])
      2'd0: f_val = (wb & wc) | (~wb & wd);
      2'd1: f_val = (wd & wb) | (~wd & wc);
      2'd2: f_val = wb ^ wc ^ wd;
      default: f_val = wc ^ (wb | ~wd);
    endcase
  end
  assign sum = f_val + wa + step_const(step_index) + m_word;
  assign sh  = step_shift(step_index);
  assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

  always_ff @(posedge clk) begin
    if (put) begin
      buf_mem[byte_position[5:2]][8 * byte_position[1:0] +: 8] <= put_byte;
    end
    if (state == ST_IDLE && cmd_take && cmd_data.is_end) begin
      len_latch <= bit_length + (cmd_data.has_byte ? 64'd8 : 64'd0);
    end
    if (rst) begin
      state         <= ST_IDLE;
      cha <= INIT_A; chb <= INIT_B; chc <= INIT_C; chd <= INIT_D;
      wa <= '0; wb <= '0; wc <= '0; wd <= '0;
      bit_length    <= '0;
      byte_position <= '0;
      step_index    <= '0;
      emit_idx      <= '0;
      resume        <= ST_IDLE;
      ending        <= 1'b0;
    end else begin
      state <= state_next;
      if (put) byte_position <= byte_position + 6'd1;
      if (state == ST_IDLE && cmd_take) begin
        if (cmd_data.has_byte) bit_length <= bit_length + 64'd8;
        ending <= 1'b1;
        if (cmd_data.is_end) resume <= ST_PAD;
        else resume <= ST_IDLE;
      end
      if (state == ST_PAD) begin
        ending <= 1'b0;
        if (byte_position == 6'd63) resume <= ST_PAD;
      end
      if (state == ST_LEN && byte_position == 6'd63) resume <= ST_EMIT;
      if (state_next == ST_COMP && state != ST_COMP) begin
        wa <= cha; wb <= chb; wc <= chc; wd <= chd;
        step_index <= '0;
      end
      if (state == ST_COMP) begin
        wa <= wd; wd <= wc; wc <= wb; wb <= wb + rot;
        step_index <= step_index + 6'd1;
        if (step_index == 6'd63) begin
          cha <= cha + wd; chb <= chb + wb + rot;
          chc <= chc + wb; chd <= chd + wc;
        end
      end
      if (out_take) begin
        emit_idx <= emit_idx + 2'd1;
        if (emit_idx == 2'd3) begin
          cha <= INIT_A; chb <= INIT_B; chc <= INIT_C; chd <= INIT_D;
          bit_length    <= '0;
          byte_position <= '0;
        end
      end
    end
  end

  assign out_valid = (state == ST_EMIT);
  always_comb begin
    case (emit_idx)
      2'd0: out_data.digest_word = cha;
      2'd1: out_data.digest_word = chb;
      2'd2: out_data.digest_word = chc;
      default: out_data.digest_word = chd;
    endcase
    out_data.word_number = emit_idx;
    out_data.last_word   = (emit_idx == 2'd3);
  end

endmodule

// File: rtl/md5_checker.sv
// ----------------------------------------------------------------------------
// md5_checker: port-level checks for the MD5 hash engine
// Digest word ordering and result handshake.
// ----------------------------------------------------------------------------
module md5_checker
  import md5_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input md5_out_t out_data,
  input logic     out_stall
);

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_number == 2'd3)))
    else $error("last_word mismatch");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.word_number != 2'd3) |=>
      (out_valid && out_data.word_number == $past(out_data.word_number) + 2'd1))
    else $error("digest words out of order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind md5_hash_engine md5_checker u_md5_checker (
  .clk, .rst, .out_valid, .out_data, .out_stall
);

// File: sim/tb_md5_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md5_hash_engine: self-checking bench for the MD5 hash engine
// Streams byte requests (directed edge messages, then random messages),
// predicts each digest with a behavioral MD5 and checks every result word.
// ----------------------------------------------------------------------------
import md5_pkg::*;

class md5_scoreboard;
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [63:0] nbits;
  logic [5:0]  pos;
  md5_out_t    pending_words [$];
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
    nbits = '0;
    pos = '0;
  endfunction

  function logic [31:0] sine_const(int i);
    return 32'(longint'($floor($pow(2.0, 32.0) * (($sin(i + 1) < 0) ?
           -$sin(i + 1) : $sin(i + 1)))));
  endfunction

  function void compress();
    logic [31:0] a, b, c, d, f, t;
    int sh [4][4];
    int g, rnd;
    sh = '{'{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      f = f + a + sine_const(i) + blk[g];
      t = (f << sh[rnd][i % 4]) | (f >> (32 - sh[rnd][i % 4]));
      a = d; d = c; c = b; b = b + t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function void append(logic [7:0] v);
    blk[pos[5:2]][pos[1:0] * 8 +: 8] = v;
    pos++;
    if (pos == 0) compress();
  endfunction

  // accepted input request
  function void note_request(md5_in_t r);
    logic [63:0] len;
    md5_out_t w;
    if (r.byte_present) begin
      nbits += 64'd8;
      append(r.data_byte);
    end
    if (!r.message_end) return;
    len = nbits;
    append(8'h80);
    while (pos != 6'd56) append(8'h00);
    for (int k = 0; k < 8; k++) append(len[8 * k +: 8]);
    for (int k = 0; k < 4; k++) begin
      w.digest_word = chain[k];
      w.word_number = 2'(k);
      w.last_word = (k == 3);
      pending_words.push_back(w);
    end
    restart();
  endfunction

  function void check_word(md5_out_t got);
    md5_out_t exp;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected digest word %h", $time, got);
      errors++;
      return;
    end
    exp = pending_words.pop_front();
    if (got.digest_word !== exp.digest_word) begin
      $display("%0t: digest_word exp %h got %h", $time, exp.digest_word, got.digest_word);
      errors++;
    end
    if (got.word_number !== exp.word_number) begin
      $display("%0t: word_number exp %0d got %0d", $time, exp.word_number, got.word_number);
      errors++;
    end
    if (got.last_word !== exp.last_word) begin
      $display("%0t: last_word exp %0d got %0d", $time, exp.last_word, got.last_word);
      errors++;
    end
  endfunction
endclass

module tb_md5_hash_engine;
  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  md5_in_t  in_data = '0;
  logic     in_stall;
  logic     out_valid;
  md5_out_t out_data;
  logic     out_stall = 1'b0;

  md5_scoreboard digests = new();
  int  sent;        // requests accepted so far
  bit  quiet;       // final stretch: no idling on either side
  bit  hold_done;   // long receiver hold-off already performed

  md5_hash_engine uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_data(in_data),
    .in_stall(in_stall), .out_valid(out_valid), .out_data(out_data),
    .out_stall(out_stall)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one request from a falling edge and hold it until accepted.
  // Valid stays high across back-to-back requests; random gaps come first.
  task automatic send_request(logic [7:0] b, logic p, logic e);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, byte_present: p, message_end: e};
    do @(posedge clk); while (in_stall);
    digests.note_request(in_data);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit empty_end);
    for (int i = 0; i < len; i++)
      send_request(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
    if (empty_end || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stall bursts, plus one long hold-off once the sender is busy.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && sent > 40) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
    end
  end

  // Result monitor: sample at the rising edge.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) digests.check_word(out_data);

  initial begin
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty message, all-zero/all-one bytes, padding boundaries
    // (55/56/64 bytes force one or two padding blocks), ignored requests.
    send_request(8'hff, 1'b0, 1'b1);              // empty message
    send_request(8'hff, 1'b0, 1'b0);              // no byte, no end: ignored
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);              // byte that also ends
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'ha5, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);              // empty end after bytes
    send_message(55, 0);
    send_message(56, 0);
    send_message(64, 1);

    // Random: mostly well-formed messages, some noise requests between.
    while (sent < 210) begin
      if ($urandom_range(0, 9) == 0)
        send_request(8'($urandom), 1'b0, 1'b0);
      else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
        send_message(n, $urandom_range(0, 3) == 0);
      end
      if (sent > 190) quiet = 1'b1;
    end
    in_valid <= 1'b0;

    while (digests.pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (digests.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
